// ----- hw/rtl/running_rank_counter_assert.svh -----
// Assertion macros used by the checker file.
`ifndef RUNNING_RANK_COUNTER_ASSERT_SVH
`define RUNNING_RANK_COUNTER_ASSERT_SVH

// Plain property, sampled on the rising edge, off while reset is low.
`define RRC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("running_rank_counter assertion failed");

// Overlapping implication a |-> c.
`define RRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  `RRC_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

// ----- hw/rtl/rrc_pkg.sv -----
package rrc_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 1024;
  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned RANK_W        = 11;
  localparam int unsigned RANK_TDATA_W  = 16;

  // Control part of a token moving down the cell row.
  typedef struct packed {
    logic valid;
    logic full;
  } rrc_ctl_t;

endpackage

// ----- hw/rtl/running_rank_counter.sv -----
// Ranks each incoming 64-bit value among the values of the current set, 1 for the
// largest. Every beat walks down a row of MaxItems cells, one cell per cycle; the
// cell whose index equals the set size at entry keeps the value, and every cell
// below that size adds one to the beat's count when its stored value is smaller.
// A new beat is taken every cycle unless the output beat is stalled; each result
// passes the whole cell row and then the output register, and the row holds while
// the output beat is stalled. tuser on the input starts a new set; tuser on the output
// flags a beat that found the store full (rank 0, value dropped).
module running_rank_counter #(
  parameter int unsigned MaxItems = rrc_pkg::MAX_ITEMS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [rrc_pkg::VALUE_W-1:0]        s_axis_tdata_i,   // [63:0] value
  input  logic                               s_axis_tuser_i,   // [0] start_req
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [rrc_pkg::RANK_TDATA_W-1:0]   m_axis_tdata_o,   // [10:0] rank, rest 0
  output logic                               m_axis_tuser_o    // [0] full_res
);
  import rrc_pkg::*;

  localparam int unsigned CntW = $clog2(MaxItems + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxItems);

  logic                en;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     base;
  logic                in_full;

  rrc_ctl_t            ctl     [MaxItems+1];
  logic [VALUE_W-1:0]  value   [MaxItems+1];
  logic [CntW-1:0]     cnt     [MaxItems+1];
  logic [CntW-1:0]     smaller [MaxItems+1];

  logic                out_vq;
  logic [RANK_W-1:0]   rank_q, rank_d;
  logic                full_q;
  logic [CntW-1:0]     rank_sum;

  // Advance the whole row unless the output beat is stalled.
  assign en              = !out_vq || m_axis_tready_i;
  assign s_axis_tready_o = en;

  assign base    = s_axis_tuser_i ? '0 : count_q;
  assign in_full = (base >= MaxCnt);
  assign count_d = in_full ? base : base + {{(CntW-1){1'b0}}, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (s_axis_tvalid_i && en) begin
      count_q <= count_d;
    end
  end

  assign ctl[0].valid = s_axis_tvalid_i;
  assign ctl[0].full  = in_full;
  assign value[0]     = s_axis_tdata_i;
  assign cnt[0]       = base;
  assign smaller[0]   = '0;

  for (genvar i = 0; i < MaxItems; i++) begin : g_cell
    rrc_cell #(
      .CntW (CntW),
      .Idx  (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .ctl_i     (ctl[i]),
      .value_i   (value[i]),
      .cnt_i     (cnt[i]),
      .smaller_i (smaller[i]),
      .ctl_o     (ctl[i+1]),
      .value_o   (value[i+1]),
      .cnt_o     (cnt[i+1]),
      .smaller_o (smaller[i+1])
    );
  end

  // Rank is the item number minus the smaller stored values.
  assign rank_sum = cnt[MaxItems] + {{(CntW-1){1'b0}}, 1'b1} - smaller[MaxItems];
  assign rank_d   = ctl[MaxItems].full ? '0 : RANK_W'(rank_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (en) begin
      out_vq <= ctl[MaxItems].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rank_q <= rank_d;
      full_q <= ctl[MaxItems].full;
    end
  end

  assign m_axis_tvalid_o = out_vq;
  assign m_axis_tdata_o  = {{(RANK_TDATA_W-RANK_W){1'b0}}, rank_q};
  assign m_axis_tuser_o  = full_q;

endmodule

// ----- hw/rtl/rrc_cell.sv -----
module rrc_cell #(
  parameter int unsigned CntW = 11,
  parameter int unsigned Idx  = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  rrc_pkg::rrc_ctl_t             ctl_i,
  input  logic [rrc_pkg::VALUE_W-1:0]   value_i,
  input  logic [CntW-1:0]               cnt_i,
  input  logic [CntW-1:0]               smaller_i,
  output rrc_pkg::rrc_ctl_t             ctl_o,
  output logic [rrc_pkg::VALUE_W-1:0]   value_o,
  output logic [CntW-1:0]               cnt_o,
  output logic [CntW-1:0]               smaller_o
);
  import rrc_pkg::*;

  localparam logic [CntW-1:0] CellIdx = CntW'(Idx);

  logic [VALUE_W-1:0] stored_q;
  rrc_ctl_t           ctl_q;
  logic [VALUE_W-1:0] value_q;
  logic [CntW-1:0]    cnt_q;
  logic [CntW-1:0]    smaller_q;
  logic               live;
  logic               hit;
  logic               keep;

  // Only cells below the token's set size hold values of its set.
  assign live = ctl_i.valid && !ctl_i.full;
  assign hit  = live && (CellIdx < cnt_i) && (stored_q < value_i);
  assign keep = live && (cnt_i == CellIdx);

  always_ff @(posedge clk_i) begin
    if (en_i && keep) begin
      stored_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q   <= value_i;
      cnt_q     <= cnt_i;
      smaller_q <= smaller_i + {{(CntW-1){1'b0}}, hit};
    end
  end

  assign ctl_o     = ctl_q;
  assign value_o   = value_q;
  assign cnt_o     = cnt_q;
  assign smaller_o = smaller_q;

endmodule

// ----- hw/rtl/rrc_checker.sv -----
`include "running_rank_counter_assert.svh"

module rrc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [rrc_pkg::RANK_TDATA_W-1:0]   m_axis_tdata_o,
  input logic                               m_axis_tuser_o
);
  import rrc_pkg::*;

  // A stalled result beat stays put.
  `RRC_ASSERT_IMPL(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i ##1 1'b1, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))

  // A full-store beat carries rank zero.
  `RRC_ASSERT_IMPL(a_full_rank, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o[RANK_W-1:0] == '0)

  // Padding above the rank stays clear.
  `RRC_ASSERT_IMPL(a_pad_zero, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[RANK_TDATA_W-1:RANK_W] == '0)

endmodule

bind running_rank_counter rrc_checker u_rrc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
